// ===== rtl/core/chfbl_pkg.sv =====
// ----------------------------------------------------------------------------
// chfbl_pkg
// Shared constants, codes and command/status types of the chained free
// block list.
// ----------------------------------------------------------------------------
package chfbl_pkg;

  localparam int CACHE_DEPTH = 100;
  localparam int BLOCK_BITS  = 16;
  localparam int CNT_W       = 7;
  localparam int ADDR_W      = $clog2(CACHE_DEPTH);
  localparam int POS_W       = $clog2(CACHE_DEPTH + 1);
  localparam int CNT_MAX     = (1 << CNT_W) - 1;

  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int WORD_W   = 16;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 32;
  localparam int OUT_UW   = 5;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNLOAD = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADCOUNT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BUSY      = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_read;
  } dp_stat_t;

endpackage

// ===== rtl/core/chfbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// chfbl_ctrl
// Sequencer: accept a request, wait out the cache read for alloc and unload,
// execute, then hold the result until it is taken.
// ----------------------------------------------------------------------------
module chfbl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  chfbl_pkg::dp_stat_t stat,
  output chfbl_pkg::dp_cmd_t  cmd
);
  import chfbl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.needs_read ? S_READ : S_EXEC;
        end
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/chfbl_datapath.sv =====
// ----------------------------------------------------------------------------
// chfbl_datapath
// Block number cache, count, transfer positions and pending flags; executes
// one request and registers its result.
// ----------------------------------------------------------------------------
module chfbl_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  chfbl_pkg::dp_cmd_t            cmd,
  output chfbl_pkg::dp_stat_t           stat,
  input  logic [chfbl_pkg::IN_DW-1:0]   in_tdata,
  input  logic [chfbl_pkg::OP_W-1:0]    in_tuser,
  output logic [chfbl_pkg::OUT_DW-1:0]  out_tdata,
  output logic [chfbl_pkg::OUT_UW-1:0]  out_tuser
);
  import chfbl_pkg::*;

  logic [BLOCK_BITS-1:0] mem [CACHE_DEPTH];
  logic [BLOCK_BITS-1:0] rdata;

  logic [OP_W-1:0]       op;
  logic [BLOCK_BITS-1:0] bn;
  logic [WORD_W-1:0]     dw;

  logic [CNT_W-1:0]      cnt;
  logic [POS_W-1:0]      lpos;
  logic [POS_W-1:0]      upos;
  logic                  fill_pending;
  logic                  spill_pending;
  logic [BLOCK_BITS-1:0] spill_target;

  logic [CNT_W-1:0]      cnt_next;
  logic [POS_W-1:0]      lpos_next;
  logic [POS_W-1:0]      upos_next;
  logic                  fill_next;
  logic                  spill_next;
  logic [BLOCK_BITS-1:0] target_next;

  logic [CNT_W-1:0]      cnt_dec;
  logic [POS_W-1:0]      lpos_dec;
  logic [POS_W-1:0]      upos_dec;
  logic [ADDR_W-1:0]     raddr;
  logic                  wen;
  logic [ADDR_W-1:0]     waddr;
  logic [BLOCK_BITS-1:0] wdata;

  logic [STAT_W-1:0]     r_status;
  logic [BLOCK_BITS-1:0] r_block;
  logic                  r_fill;
  logic                  r_spill;
  logic [WORD_W-1:0]     r_word;
  logic                  r_done;

  logic [STAT_W-1:0]     res_status;
  logic [BLOCK_BITS-1:0] res_block;
  logic                  res_fill;
  logic                  res_spill;
  logic [WORD_W-1:0]     res_word;
  logic                  res_done;

  assign stat.needs_read = (in_tuser == OP_ALLOC) || (in_tuser == OP_UNLOAD);

  assign cnt_dec  = cnt - 1'b1;
  assign lpos_dec = lpos - 1'b1;
  assign upos_dec = upos - 1'b1;
  assign raddr    = (op == OP_ALLOC) ? cnt_dec[ADDR_W-1:0] : upos_dec[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_tuser;
      bn <= in_tdata[BLOCK_BITS-1:0];
      dw <= in_tdata[IN_DW-1:WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    cnt_next    = cnt;
    lpos_next   = lpos;
    upos_next   = upos;
    fill_next   = fill_pending;
    spill_next  = spill_pending;
    target_next = spill_target;
    wen         = 1'b0;
    waddr       = cnt[ADDR_W-1:0];
    wdata       = bn;
    res_status  = STAT_OK;
    res_block   = '0;
    res_fill    = 1'b0;
    res_spill   = 1'b0;
    res_word    = '0;
    res_done    = 1'b0;
    case (op)
      OP_ALLOC: begin
        if (fill_pending || spill_pending) begin
          res_status = STAT_BUSY;
        end else if (cnt == '0 || cnt > CNT_W'(CACHE_DEPTH)) begin
          res_status = STAT_BADCOUNT;
        end else if (rdata == '0) begin
          res_status = STAT_EXHAUSTED;
        end else begin
          cnt_next  = cnt_dec;
          res_block = rdata;
          if (cnt_dec == '0) begin
            fill_next = 1'b1;
            lpos_next = '0;
            res_fill  = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (fill_pending || spill_pending) begin
          res_status = STAT_BUSY;
        end else if (cnt >= CNT_W'(CACHE_DEPTH)) begin
          spill_next  = 1'b1;
          target_next = bn;
          upos_next   = '0;
          res_block   = bn;
          res_spill   = 1'b1;
        end else begin
          wen      = 1'b1;
          waddr    = cnt[ADDR_W-1:0];
          wdata    = bn;
          cnt_next = cnt + 1'b1;
        end
      end
      OP_LOAD: begin
        if (spill_pending) begin
          res_status = STAT_BUSY;
        end else begin
          if (lpos == '0) begin
            cnt_next = (dw > WORD_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : dw[CNT_W-1:0];
          end else if (lpos <= POS_W'(CACHE_DEPTH)) begin
            wen   = 1'b1;
            waddr = lpos_dec[ADDR_W-1:0];
            wdata = dw[BLOCK_BITS-1:0];
          end
          if (lpos >= POS_W'(CACHE_DEPTH)) begin
            lpos_next = '0;
            fill_next = 1'b0;
            res_done  = 1'b1;
          end else begin
            lpos_next = lpos + 1'b1;
          end
        end
      end
      OP_UNLOAD: begin
        if (spill_pending) begin
          if (upos == '0) begin
            res_word = WORD_W'(cnt);
          end else begin
            res_word = rdata;
          end
          if (upos >= POS_W'(CACHE_DEPTH)) begin
            upos_next  = '0;
            spill_next = 1'b0;
            wen        = 1'b1;
            waddr      = '0;
            wdata      = spill_target;
            cnt_next   = CNT_W'(1);
            res_done   = 1'b1;
          end else begin
            upos_next = upos + 1'b1;
          end
        end
      end
      default: res_status = STAT_OK;
    endcase
    if (!cmd.exec) begin
      wen = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      lpos          <= '0;
      upos          <= '0;
      fill_pending  <= 1'b0;
      spill_pending <= 1'b0;
      spill_target  <= '0;
    end else if (cmd.exec) begin
      cnt           <= cnt_next;
      lpos          <= lpos_next;
      upos          <= upos_next;
      fill_pending  <= fill_next;
      spill_pending <= spill_next;
      spill_target  <= target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_status <= res_status;
      r_block  <= res_block;
      r_fill   <= res_fill;
      r_spill  <= res_spill;
      r_word   <= res_word;
      r_done   <= res_done;
    end
  end

  assign out_tdata = {r_word, r_block};
  assign out_tuser = {r_done, r_spill, r_fill, r_status};

endmodule

// ===== rtl/core/chained_free_block_list.sv =====
// Alloc and unload_word pass through a read state for the registered cache
//   read before they execute; free and load_word go straight to execution.
// One request is in flight at a time, and the next is taken once the result
//   has been taken.
// Reset: synchronous, active high; clears count, positions and pending flags.
//   Cache entries are not cleared.
// ----------------------------------------------------------------------------
// chained_free_block_list
// Free block allocator with a 100-entry cache of block numbers chained
// through disk blocks, filled and spilled word by word by the host.
// ----------------------------------------------------------------------------
module chained_free_block_list (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [chfbl_pkg::IN_DW-1:0]  s_axis_tdata,  // block_number, data_word
  input  logic [chfbl_pkg::OP_W-1:0]   s_axis_tuser,  // operation
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [chfbl_pkg::OUT_DW-1:0] m_axis_tdata,  // block, word_out
  output logic [chfbl_pkg::OUT_UW-1:0] m_axis_tuser   // status, fill_request,
                                                      // spill_request, transfer_done
);
  import chfbl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  chfbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  chfbl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (s_axis_tdata),
    .in_tuser  (s_axis_tuser),
    .out_tdata (m_axis_tdata),
    .out_tuser (m_axis_tuser)
  );

endmodule

// ===== rtl/core/chfbl_checker.sv =====
// ----------------------------------------------------------------------------
// chfbl_checker
// Port-level checks of the chained free block list results.
// ----------------------------------------------------------------------------
module chfbl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [chfbl_pkg::OUT_DW-1:0] m_axis_tdata,
  input logic [chfbl_pkg::OUT_UW-1:0] m_axis_tuser
);
  import chfbl_pkg::*;

  a_fill_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tuser[1:0] == STAT_OK && !m_axis_tuser[3] && m_axis_tdata[15:0] != '0)
    else $error("fill request without a good allocation");

  a_spill_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tuser[1:0] == STAT_OK && !m_axis_tuser[4])
    else $error("spill request with bad status or transfer end");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[4] |->
      m_axis_tuser[1:0] == STAT_OK && m_axis_tdata[15:0] == '0)
    else $error("transfer end with bad status or block");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind chained_free_block_list chfbl_checker u_chk (.*);
